// ----- rtl/core/tmad_pkg.sv -----
// Shared types and constants for the text markup attribute decoder.
// Used by every module in rtl/core; depends on nothing.
package tmad_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned STYLE_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [SIZE_W-1:0]   RST_BASE_SIZE     = 8'd14;
  localparam logic [COLOUR_W-1:0] RST_BASE_COLOUR   = 24'hFFFFFF;
  localparam logic [STYLE_W-1:0]  RST_BASE_STYLE    = 4'h0;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_BAD    = 24'hFF0000;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_GOOD   = 24'h00FF00;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_NORMAL = 24'hFFFFFF;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_BLACK  = 24'h000000;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_GRAY   = 24'h808080;

  localparam logic [BYTE_W-1:0] CH_BOLD   = 8'h7E; // '~'
  localparam logic [BYTE_W-1:0] CH_INC    = 8'h2A; // '*'
  localparam logic [BYTE_W-1:0] CH_DEC    = 8'h60; // '`'
  localparam logic [BYTE_W-1:0] CH_NORMAL = 8'h7B; // '{'
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E; // '^'
  localparam logic [BYTE_W-1:0] CH_BLACK  = 8'h7D; // '}'
  localparam logic [BYTE_W-1:0] CH_GRAY   = 8'h7C; // '|'
  localparam logic [BYTE_W-1:0] CH_GOOD   = 8'h40; // '@'
  localparam logic [BYTE_W-1:0] CH_BAD    = 8'h23; // '#'
  localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h3C; // '<'
  localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h3E; // '>'
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h5C; // backslash
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_SIZE     = 3'd0,
    REG_BASE_COLOUR   = 3'd1,
    REG_BASE_STYLE    = 3'd2,
    REG_COLOUR_BAD    = 3'd3,
    REG_COLOUR_GOOD   = 3'd4,
    REG_COLOUR_NORMAL = 3'd5,
    REG_COLOUR_BLACK  = 3'd6,
    REG_COLOUR_GRAY   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    K_OTHER  = 4'd0,
    K_ESC    = 4'd1,
    K_BAD    = 4'd2,
    K_GOOD   = 4'd3,
    K_NORMAL = 4'd4,
    K_BLACK  = 4'd5,
    K_GRAY   = 4'd6,
    K_INC    = 4'd7,
    K_DEC    = 4'd8,
    K_BOLD   = 4'd9,
    K_CARET  = 4'd10,
    K_OPEN   = 4'd11,
    K_CLOSE  = 4'd12,
    K_DIGIT  = 4'd13
  } kind_t;

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_TEXT   = 6'b000010,
    PH_ESC    = 6'b000100,
    PH_RED    = 6'b001000,
    PH_GREEN  = 6'b010000,
    PH_BLUE   = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        digit;
    logic [BYTE_W-1:0] text_byte;
    logic              line_end;
  } entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   base_size;
    logic [COLOUR_W-1:0] base_colour;
    logic [STYLE_W-1:0]  base_style;
    logic [COLOUR_W-1:0] colour_bad;
    logic [COLOUR_W-1:0] colour_good;
    logic [COLOUR_W-1:0] colour_normal;
    logic [COLOUR_W-1:0] colour_black;
    logic [COLOUR_W-1:0] colour_gray;
  } cfg_t;

endpackage

// ----- rtl/core/tmad_classify.sv -----
// Front end: tags each incoming byte with its markup kind.
// Depends on tmad_pkg.
module tmad_classify (
  input  logic [tmad_pkg::BYTE_W-1:0] text_byte,
  input  logic                        line_end,
  output tmad_pkg::entry_t            entry
);
  import tmad_pkg::*;

  kind_t kind;

  always_comb begin
    priority if (text_byte == CH_ESC)    kind = K_ESC;
    else if (text_byte == CH_BAD)        kind = K_BAD;
    else if (text_byte == CH_GOOD)       kind = K_GOOD;
    else if (text_byte == CH_NORMAL)     kind = K_NORMAL;
    else if (text_byte == CH_BLACK)      kind = K_BLACK;
    else if (text_byte == CH_GRAY)       kind = K_GRAY;
    else if (text_byte == CH_INC)        kind = K_INC;
    else if (text_byte == CH_DEC)        kind = K_DEC;
    else if (text_byte == CH_BOLD)       kind = K_BOLD;
    else if (text_byte == CH_CARET)      kind = K_CARET;
    else if (text_byte == CH_OPEN)       kind = K_OPEN;
    else if (text_byte == CH_CLOSE)      kind = K_CLOSE;
    else if (text_byte >= CH_ZERO && text_byte <= CH_NINE) kind = K_DIGIT;
    else                                 kind = K_OTHER;
  end

  logic [BYTE_W-1:0] digit_full;
  assign digit_full = text_byte - CH_ZERO;

  assign entry.kind      = kind;
  assign entry.digit     = digit_full[3:0];
  assign entry.text_byte = text_byte;
  assign entry.line_end  = line_end;

endmodule

// ----- rtl/core/tmad_queue.sv -----
// Small FIFO of classified requests between front and back end.
// Depends on tmad_pkg.
module tmad_queue #(
  parameter int unsigned DEPTH = tmad_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tmad_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output tmad_pkg::entry_t  pop_data,
  output logic              not_empty
);
  import tmad_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/tmad_exec.sv -----
// Back end: runs the prefix state machine on classified requests and
// holds the output register. Depends on tmad_pkg.
module tmad_exec (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmad_pkg::cfg_t                    cfg,
  input  logic                              q_valid,
  input  tmad_pkg::entry_t                  q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tmad_pkg::BYTE_W-1:0]       out_byte,
  output logic [tmad_pkg::SIZE_W-1:0]       out_size,
  output logic [tmad_pkg::COLOUR_W-1:0]     out_colour,
  output logic [tmad_pkg::STYLE_W-1:0]      out_style,
  output logic                              out_line_end
);
  import tmad_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic [STYLE_W-1:0]  style_r, style_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;
  logic [7:0]          blue_r, blue_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [COLOUR_W-1:0] out_colour_r;
  logic [STYLE_W-1:0]  out_style_r;
  logic                out_last_r;
  logic                emit;
  logic [7:0]          acc_sel, acc_new;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    unique case (phase_r)
      PH_RED:   acc_sel = red_r;
      PH_GREEN: acc_sel = green_r;
      default:  acc_sel = blue_r;
    endcase
  end

  // acc * 10 + digit, modulo 256
  assign acc_new = {acc_sel[4:0], 3'b000} + {acc_sel[6:0], 1'b0} + {4'b0000, q_data.digit};

  always_comb begin
    phase_nxt  = phase_r;
    size_nxt   = size_r;
    colour_nxt = colour_r;
    style_nxt  = style_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    emit       = 1'b0;
    if (q_pop) begin
      unique case (phase_r)
        PH_PREFIX: begin
          unique case (q_data.kind)
            K_ESC:    phase_nxt = PH_ESC;
            K_BAD:    colour_nxt = cfg.colour_bad;
            K_GOOD:   colour_nxt = cfg.colour_good;
            K_NORMAL: colour_nxt = cfg.colour_normal;
            K_BLACK:  colour_nxt = cfg.colour_black;
            K_GRAY:   colour_nxt = cfg.colour_gray;
            K_INC:    size_nxt = (size_r >= 8'd253) ? 8'd255 : size_r + 8'd2;
            K_DEC:    size_nxt = (size_r <= 8'd2) ? 8'd0 : size_r - 8'd2;
            K_BOLD:   style_nxt = style_r | 4'b0001;
            K_CARET:  phase_nxt = PH_TEXT;
            K_OPEN: begin
              red_nxt   = '0;
              green_nxt = '0;
              blue_nxt  = '0;
              phase_nxt = PH_RED;
            end
            default: begin
              emit      = 1'b1;
              phase_nxt = PH_TEXT;
            end
          endcase
        end
        PH_RED, PH_GREEN, PH_BLUE: begin
          priority if (q_data.kind == K_DIGIT) begin
            if (phase_r == PH_RED) begin
              red_nxt = acc_new;
            end else if (phase_r == PH_GREEN) begin
              green_nxt = acc_new;
            end else begin
              blue_nxt = acc_new;
            end
          end else if (q_data.kind == K_CLOSE) begin
            colour_nxt = {red_r, green_r, blue_r};
            phase_nxt  = PH_PREFIX;
          end else if (phase_r == PH_RED) begin
            phase_nxt = PH_GREEN;
          end else if (phase_r == PH_GREEN) begin
            phase_nxt = PH_BLUE;
          end else begin
            phase_nxt = PH_PREFIX;
          end
        end
        default: begin
          emit      = 1'b1;
          phase_nxt = PH_TEXT;
        end
      endcase
      if (q_data.line_end) begin
        phase_nxt  = PH_PREFIX;
        size_nxt   = cfg.base_size;
        colour_nxt = cfg.base_colour;
        style_nxt  = cfg.base_style;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PREFIX;
      size_r      <= RST_BASE_SIZE;
      colour_r    <= RST_BASE_COLOUR;
      style_r     <= RST_BASE_STYLE;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      size_r      <= size_nxt;
      colour_r    <= colour_nxt;
      style_r     <= style_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: emitted bytes never change attributes, so current values apply
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_byte_r   <= q_data.text_byte;
      out_size_r   <= size_r;
      out_colour_r <= colour_r;
      out_style_r  <= style_r;
      out_last_r   <= q_data.line_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_size     = out_size_r;
  assign out_colour   = out_colour_r;
  assign out_style    = out_style_r;
  assign out_line_end = out_last_r;

endmodule

// ----- rtl/core/text_markup_attribute_decoder.sv -----
// Top level of the text markup attribute decoder: configuration registers,
// front classifier, request queue and back-end state machine.
// Depends on tmad_pkg, tmad_classify, tmad_queue, tmad_exec.
//
// Takes one byte of a text line per cycle and decodes its markup prefix
// (size, colour, bold, <r,g,b> groups, caret, backslash escape); text bytes
// leave with the size, colour and style in force, attributes return to the
// base registers after each line end. Sustained rate is one byte per cycle:
// the classifier feeds a QUEUE_DEPTH-entry queue and the back end retires one
// request per cycle into a single output register, which keeps moving while
// out_tready is high. Prefix bytes give no output. An input request passes
// through the queue register and then the output register. in_tready drops
// only when the queue is full. Base registers take effect at the next line
// end or reset; colour registers at the next mark using them.
module text_markup_attribute_decoder #(
  parameter int unsigned QUEUE_DEPTH = tmad_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] text_byte
  input  logic                                in_tlast,   // line_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] out_byte, [15:8] out_size, [39:16] out_colour, [43:40] out_style
  output logic [tmad_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // out_line_end
  input  logic                                cfg_we,
  input  logic [tmad_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tmad_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tmad_pkg::*;

  cfg_t                cfg_r;
  entry_t              front_entry;
  entry_t              q_data;
  logic                q_full, q_valid, q_pop, push;
  logic [BYTE_W-1:0]   o_byte;
  logic [SIZE_W-1:0]   o_size;
  logic [COLOUR_W-1:0] o_colour;
  logic [STYLE_W-1:0]  o_style;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_size     <= RST_BASE_SIZE;
      cfg_r.base_colour   <= RST_BASE_COLOUR;
      cfg_r.base_style    <= RST_BASE_STYLE;
      cfg_r.colour_bad    <= RST_COLOUR_BAD;
      cfg_r.colour_good   <= RST_COLOUR_GOOD;
      cfg_r.colour_normal <= RST_COLOUR_NORMAL;
      cfg_r.colour_black  <= RST_COLOUR_BLACK;
      cfg_r.colour_gray   <= RST_COLOUR_GRAY;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_BASE_SIZE:     cfg_r.base_size     <= cfg_wdata[SIZE_W-1:0];
        REG_BASE_COLOUR:   cfg_r.base_colour   <= cfg_wdata[COLOUR_W-1:0];
        REG_BASE_STYLE:    cfg_r.base_style    <= cfg_wdata[STYLE_W-1:0];
        REG_COLOUR_BAD:    cfg_r.colour_bad    <= cfg_wdata[COLOUR_W-1:0];
        REG_COLOUR_GOOD:   cfg_r.colour_good   <= cfg_wdata[COLOUR_W-1:0];
        REG_COLOUR_NORMAL: cfg_r.colour_normal <= cfg_wdata[COLOUR_W-1:0];
        REG_COLOUR_BLACK:  cfg_r.colour_black  <= cfg_wdata[COLOUR_W-1:0];
        REG_COLOUR_GRAY:   cfg_r.colour_gray   <= cfg_wdata[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  tmad_classify u_classify (
    .text_byte (in_tdata),
    .line_end  (in_tlast),
    .entry     (front_entry)
  );

  tmad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  tmad_exec u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (o_byte),
    .out_size     (o_size),
    .out_colour   (o_colour),
    .out_style    (o_style),
    .out_line_end (out_tlast)
  );

  assign out_tdata = {4'b0000, o_style, o_colour, o_size, o_byte};

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for text_markup_attribute_decoder.
// Needs tmad_pkg and the decoder RTL; a scoreboard class predicts the emitted
// glyphs and their attributes from each accepted byte request.
module tb;
  import tmad_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  size;
    logic [23:0] colour;
    logic [3:0]  style;
    logic        last;
  } glyph_t;

  class attr_tracker;
    cfg_t        regs;
    phase_t      ph;
    logic [7:0]  size;
    logic [23:0] colour;
    logic [3:0]  style;
    logic [7:0]  r_acc, g_acc, b_acc;
    glyph_t      pending[$];
    int          errors;

    function new();
      regs.base_size     = RST_BASE_SIZE;
      regs.base_colour   = RST_BASE_COLOUR;
      regs.base_style    = RST_BASE_STYLE;
      regs.colour_bad    = RST_COLOUR_BAD;
      regs.colour_good   = RST_COLOUR_GOOD;
      regs.colour_normal = RST_COLOUR_NORMAL;
      regs.colour_black  = RST_COLOUR_BLACK;
      regs.colour_gray   = RST_COLOUR_GRAY;
      r_acc = '0;
      g_acc = '0;
      b_acc = '0;
      errors = 0;
      restore();
    endfunction

    function void restore();
      ph     = PH_PREFIX;
      size   = regs.base_size;
      colour = regs.base_colour;
      style  = regs.base_style;
    endfunction

    function void set_reg(reg_idx_t idx, logic [23:0] v);
      case (idx)
        REG_BASE_SIZE:     regs.base_size     = v[7:0];
        REG_BASE_COLOUR:   regs.base_colour   = v;
        REG_BASE_STYLE:    regs.base_style    = v[3:0];
        REG_COLOUR_BAD:    regs.colour_bad    = v;
        REG_COLOUR_GOOD:   regs.colour_good   = v;
        REG_COLOUR_NORMAL: regs.colour_normal = v;
        REG_COLOUR_BLACK:  regs.colour_black  = v;
        REG_COLOUR_GRAY:   regs.colour_gray   = v;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] ch, logic last);
      logic   emit;
      logic   is_digit;
      glyph_t g;
      emit = 1'b0;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      case (ph)
        PH_PREFIX: begin
          case (ch)
            CH_ESC:    ph = PH_ESC;
            CH_BAD:    colour = regs.colour_bad;
            CH_GOOD:   colour = regs.colour_good;
            CH_NORMAL: colour = regs.colour_normal;
            CH_BLACK:  colour = regs.colour_black;
            CH_GRAY:   colour = regs.colour_gray;
            CH_INC:    size = (size >= 8'd253) ? 8'd255 : size + 8'd2;
            CH_DEC:    size = (size <= 8'd2) ? 8'd0 : size - 8'd2;
            CH_BOLD:   style = style | 4'd1;
            CH_CARET:  ph = PH_TEXT;
            CH_OPEN: begin
              r_acc = '0;
              g_acc = '0;
              b_acc = '0;
              ph = PH_RED;
            end
            default: begin
              emit = 1'b1;
              ph = PH_TEXT;
            end
          endcase
        end
        PH_RED, PH_GREEN, PH_BLUE: begin
          if (is_digit) begin
            if (ph == PH_RED) r_acc = r_acc * 8'd10 + (ch - CH_ZERO);
            else if (ph == PH_GREEN) g_acc = g_acc * 8'd10 + (ch - CH_ZERO);
            else b_acc = b_acc * 8'd10 + (ch - CH_ZERO);
          end else if (ch == CH_CLOSE) begin
            colour = {r_acc, g_acc, b_acc};
            ph = PH_PREFIX;
          end else if (ph == PH_RED) begin
            ph = PH_GREEN;
          end else if (ph == PH_GREEN) begin
            ph = PH_BLUE;
          end else begin
            ph = PH_PREFIX;
          end
        end
        default: begin
          emit = 1'b1;
          ph = PH_TEXT;
        end
      endcase
      if (emit) begin
        g.ch = ch;
        g.size = size;
        g.colour = colour;
        g.style = style;
        g.last = last;
        pending.insert(pending.size(), g);
      end
      if (last) restore();
    endfunction

    function void check_emit(logic [OUT_DATA_W-1:0] d, logic last);
      glyph_t want;
      if (pending.size() == 0) begin
        $error("unexpected output glyph %0h", d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d[7:0] !== want.ch) begin
        $error("out_byte expected %0h got %0h", want.ch, d[7:0]);
        errors++;
      end
      if (d[15:8] !== want.size) begin
        $error("out_size expected %0d got %0d", want.size, d[15:8]);
        errors++;
      end
      if (d[39:16] !== want.colour) begin
        $error("out_colour expected %06h got %06h", want.colour, d[39:16]);
        errors++;
      end
      if (d[43:40] !== want.style) begin
        $error("out_style expected %0h got %0h", want.style, d[43:40]);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_line_end expected %0b got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int waiting();
      return pending.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  attr_tracker sb;
  bit          calm;
  bit          hold_req;
  logic [7:0]  line_q[$];
  logic [23:0] reg_plan[8];

  text_markup_attribute_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // one request per input byte, checked glyph per output handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_emit(out_tdata, out_tlast);
    end
  end

  task automatic send_byte(logic [7:0] ch, logic last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(string s, bit closes);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], closes && (i == s.len() - 1));
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_plan();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= reg_idx_t'(i);
      cfg_wdata <= reg_plan[i];
      sb.set_reg(reg_idx_t'(i), reg_plan[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_mark();
    case ($urandom_range(0, 7))
      0: return CH_INC;
      1: return CH_DEC;
      2: return CH_BOLD;
      3: return CH_BAD;
      4: return CH_GOOD;
      5: return CH_NORMAL;
      6: return CH_BLACK;
      default: return CH_GRAY;
    endcase
  endfunction

  function automatic logic [7:0] pick_separator();
    logic [7:0] ch;
    if ($urandom_range(0, 3) != 0) return 8'h2C;
    do ch = 8'($urandom_range(0, 255));
    while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_CLOSE);
    return ch;
  endfunction

  function automatic void push_digits();
    int n;
    n = $urandom_range(0, 3);
    for (int j = 0; j < n; j++) line_q.insert(line_q.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // mostly marks, groups and escapes followed by text; some raw noise lines
  function automatic void build_line();
    int n_marks;
    int n_text;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n_text = $urandom_range(1, 10);
      for (int k = 0; k < n_text; k++) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
      return;
    end
    n_marks = $urandom_range(0, 6);
    for (int k = 0; k < n_marks; k++) begin
      case ($urandom_range(0, 15))
        10, 11, 12: begin
          line_q.insert(line_q.size(), CH_OPEN);
          push_digits();
          line_q.insert(line_q.size(), pick_separator());
          push_digits();
          line_q.insert(line_q.size(), pick_separator());
          push_digits();
          if ($urandom_range(0, 4) == 0) line_q.insert(line_q.size(), pick_separator());
          else line_q.insert(line_q.size(), CH_CLOSE);
        end
        13: line_q.insert(line_q.size(), CH_CARET);
        14: begin
          line_q.insert(line_q.size(), CH_ESC);
          line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
        end
        15: begin
          line_q.insert(line_q.size(), CH_OPEN);
          push_digits();
        end
        default: line_q.insert(line_q.size(), pick_mark());
      endcase
    end
    n_text = $urandom_range(0, 8);
    for (int k = 0; k < n_text; k++) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
    if (line_q.size() == 0) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
  endfunction

  // receiver: random hold-off per glyph, one long hold when asked
  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int sent;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_text("*`*~#Ab", 1);
    send_text("<300;7>x", 1);
    send_text("<,,5qY", 1);
    send_text("\\*", 1);
    send_text("^~", 1);
    send_text("@}|", 1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    in_tvalid <= 1'b0;

    for (int p = 1; p <= 8; p++) begin
      drain();
      for (int i = 0; i < 8; i++) reg_plan[i] = 24'($urandom_range(0, 24'hFFFFFF));
      reg_plan[REG_BASE_SIZE]  = 24'($urandom_range(0, 255));
      reg_plan[REG_BASE_STYLE] = 24'($urandom_range(0, 15));
      case (p)
        1: for (int i = 0; i < 8; i++) reg_plan[i] = '0;
        2: begin
          for (int i = 0; i < 8; i++) reg_plan[i] = 24'hFFFFFF;
          reg_plan[REG_BASE_SIZE]  = 24'd255;
          reg_plan[REG_BASE_STYLE] = 24'd15;
        end
        3: reg_plan[REG_BASE_SIZE] = 24'd253;
        4: reg_plan[REG_BASE_SIZE] = 24'd2;
        default: ;
      endcase
      apply_plan();
      if (p == 5) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_line();
        calm = (p == 5) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
        sent += line_q.size();
      end
      calm = 1'b0;
      in_tvalid <= 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.waiting() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
